// ===== src/maft_pkg.sv =====
// Shared types, codes and helpers for the masked address filter table.
package maft_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [7:0]  OCTET_FULL = 8'hFF;

  typedef enum logic [1:0] {
    REQ_MATCH  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_IGNORE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift_start;
    logic shift;
    logic add_commit;
    logic remove_commit;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic hit;
    logic scan_end;
    logic full;
  } dp_sts_t;

  function automatic logic [31:0] pattern_mask(input logic [31:0] addr);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (addr[8*k +: 8] != 8'd0) begin
        m[8*k +: 8] = OCTET_FULL;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/maft_dp.sv =====
// Datapath: pattern memory, entry count, scan pipeline and shift-down logic.
module maft_dp import maft_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_ip_address,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  logic [31:0]   entry_compare_r [MAX_ENTRIES];

  req_t          req_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [CW-1:0] chk_idx_r;
  logic [31:0]   rd_data_r;

  logic          rd_en;
  logic          hit_cond;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW-1:0] prev_idx;

  assign rd_en    = (cmd.scan || cmd.shift) && (idx_r < count_r);
  assign prev_idx = chk_idx_r - ONE_CNT;

  always_comb begin
    case (req_r)
      REQ_MATCH:  hit_cond = (addr_r & pattern_mask(rd_data_r)) == rd_data_r;
      REQ_ADD:    hit_cond = rd_data_r == ALL_ONES;
      REQ_REMOVE: hit_cond = rd_data_r == addr_r;
      default:    hit_cond = 1'b0;
    endcase
  end

  assign sts.req      = req_r;
  assign sts.hit      = chk_vld_r && hit_cond;
  assign sts.scan_end = !chk_vld_r && (idx_r >= count_r);
  assign sts.full     = count_r == MAX_CNT;

  always_comb begin
    idx_nxt     = idx_r;
    chk_vld_nxt = 1'b0;
    count_nxt   = count_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.shift_start) begin
      idx_nxt = chk_idx_r + ONE_CNT;
    end else if (rd_en) begin
      idx_nxt     = idx_r + ONE_CNT;
      chk_vld_nxt = 1'b1;
    end
    if (cmd.add_commit && !sts.hit && !sts.full) begin
      count_nxt = count_r + ONE_CNT;
    end else if (cmd.remove_commit) begin
      count_nxt = count_r - ONE_CNT;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx_r[AW-1:0];
    wr_data = addr_r;
    if (cmd.add_commit) begin
      if (sts.hit) begin
        wr_en = 1'b1;
      end else if (!sts.full) begin
        wr_en   = 1'b1;
        wr_addr = count_r[AW-1:0];
      end
    end else if (cmd.shift && chk_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = prev_idx[AW-1:0];
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_compare_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_compare_r[idx_r[AW-1:0]];
      chk_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      addr_r <= in_ip_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

endmodule

// ===== src/maft_ctrl.sv =====
// Controller: request sequencing, configuration register and result register.
module maft_ctrl import maft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    cfg_ban_on_match,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    out_drop,
  output logic [1:0] out_status,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_t    state_r, state_nxt;
  logic    ban_r;
  logic    res_drop_r, res_drop_nxt;
  status_t res_status_r, res_status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_drop_r;
  status_t out_status_r;
  logic    out_free;
  logic    out_load;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.req)
          REQ_MATCH, REQ_ADD: begin
            if (sts.hit || sts.scan_end) begin
              state_nxt = S_DONE;
            end
          end
          REQ_REMOVE: begin
            if (sts.hit) begin
              state_nxt = S_SHIFT;
            end else if (sts.scan_end) begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    res_drop_nxt   = res_drop_r;
    res_status_nxt = res_status_r;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan       = 1'b1;
        res_drop_nxt   = 1'b0;
        res_status_nxt = STAT_OK;
        case (sts.req)
          REQ_MATCH: begin
            res_drop_nxt = ~(sts.hit ^ ban_r);
          end
          REQ_ADD: begin
            cmd.add_commit = sts.hit || sts.scan_end;
            if (!sts.hit && sts.full) begin
              res_status_nxt = STAT_FULL;
            end
          end
          REQ_REMOVE: begin
            if (sts.hit) begin
              cmd.scan        = 1'b0;
              cmd.shift_start = 1'b1;
            end else begin
              res_status_nxt = STAT_NOT_FOUND;
            end
          end
          default: begin
            cmd.scan = 1'b0;
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift          = 1'b1;
        cmd.remove_commit  = sts.scan_end;
        res_status_nxt     = STAT_OK;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_drop_r   <= res_drop_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_drop_r   <= res_drop_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ban_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ban_r <= cfg_ban_on_match;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_drop   = out_drop_r;
  assign out_status = out_status_r;

endmodule

// ===== src/masked_address_filter_table_core.sv =====
// Top level of the masked IPv4 address filter table.
//
//   channel | ports                                  | transfer when
//   --------+----------------------------------------+-------------------------
//   cfg     | cfg_we, cfg_ban_on_match               | cfg_we high
//   in      | in_valid, in_stall, in_req_type,       | in_valid && !in_stall
//           | in_ip_address                          |
//   out     | out_valid, out_stall, out_drop,        | out_valid && !out_stall
//           | out_status                             |
//
// One request at a time; the single memory read port scans one entry per cycle.
// Match and add stop at the first hit or at the end of the table; remove scans
// up to the hit and then shifts the later entries down one place.
// Synchronous active-low reset empties the table and sets ban_on_match; no
// clearing pass. A new request is taken while a result waits in the output
// register; the next result waits in its final state while out_stall is high.
module masked_address_filter_table_core import maft_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_ban_on_match,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_ip_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drop,
  output logic [1:0]  out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  maft_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_ban_on_match (cfg_ban_on_match),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drop         (out_drop),
    .out_status       (out_status),
    .sts              (sts),
    .cmd              (cmd)
  );

  maft_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_ip_address (in_ip_address),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== dv/tb_masked_address_filter_table_core.sv =====
// Self-checking testbench for the masked IPv4 address filter table core.
`timescale 1ns / 1ps

module tb_masked_address_filter_table_core;
  import maft_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    logic    drop;
    status_t status;
  } verdict_t;

  typedef struct packed {
    bit          cfg_row;
    logic        ban;
    req_t        req;
    logic [31:0] addr;
    bit          typed;
    logic        drop;
    status_t     status;
  } drow_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_ban_on_match = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_MATCH;
  logic [31:0] in_ip_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drop;
  logic [1:0]  out_status;

  logic [31:0] tbl_cmp [TABLE_DEPTH];
  logic [31:0] tbl_msk [TABLE_DEPTH];
  int          tbl_cnt = 0;
  logic        ban_mode = 1'b1;

  verdict_t pending_verdicts [$];
  verdict_t head_v;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_adds = 0;
  int missed_removes = 0;
  int dropped_matches = 0;
  int burst_left = 0;
  int cycle_cnt = 0;
  int stall_mode = 0;

  // cfg_row, ban, req, addr, typed, drop, status
  drow_t dir_table [DIR_ROWS] = '{
    '{1'b0, 1'b0, REQ_MATCH,  32'h0000_0000, 1'b1, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'hFFFF_FFFF, 1'b1, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_IGNORE, 32'hFFFF_FFFF, 1'b1, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0A00_0001, 1'b1, 1'b0, STAT_NOT_FOUND},
    '{1'b0, 1'b0, REQ_ADD,    32'h0A00_0001, 1'b1, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'h0A7F_3C01, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'h0B00_0001, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_ADD,    32'h0000_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_ADD,    32'hFFFF_FFFF, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'h1234_5678, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0000_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_ADD,    32'hC0A8_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0A00_0001, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'hC0A8_1234, 1'b0, 1'b0, STAT_OK},
    '{1'b1, 1'b0, REQ_MATCH,  32'h0000_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'hC0A8_FFFF, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'h0102_0304, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_REMOVE, 32'hC0A8_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'h0000_0000, 1'b1, 1'b1, STAT_OK},
    '{1'b0, 1'b0, REQ_ADD,    32'h0000_00FF, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_MATCH,  32'hFFFF_FFFF, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_REMOVE, 32'h0000_00FF, 1'b0, 1'b0, STAT_OK},
    '{1'b1, 1'b1, REQ_MATCH,  32'h0000_0000, 1'b0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, REQ_IGNORE, 32'h0000_0000, 1'b1, 1'b0, STAT_OK}
  };

  masked_address_filter_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_ban_on_match (cfg_ban_on_match),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_ip_address    (in_ip_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drop         (out_drop),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] wildcard_mask(logic [31:0] addr);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (addr[8*k +: 8] != 8'd0) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic verdict_t predict_verdict(req_t req, logic [31:0] addr);
    verdict_t v;
    int slot;
    bit hit;
    logic [31:0] m;
    v.drop = 1'b0;
    v.status = STAT_OK;
    slot = -1;
    hit = 1'b0;
    case (req)
      REQ_MATCH: begin
        for (int i = 0; i < tbl_cnt && !hit; i++) begin
          hit = ((addr & tbl_msk[i]) == tbl_cmp[i]);
        end
        v.drop = hit ? ban_mode : !ban_mode;
        if (v.drop) dropped_matches++;
      end
      REQ_ADD: begin
        for (int i = 0; i < tbl_cnt && slot < 0; i++) begin
          if (tbl_cmp[i] == ALL_ONES) slot = i;
        end
        if (slot < 0) begin
          if (tbl_cnt >= TABLE_DEPTH) begin
            v.status = STAT_FULL;
            full_adds++;
          end else begin
            slot = tbl_cnt;
            tbl_cnt++;
          end
        end
        if (slot >= 0) begin
          tbl_msk[slot] = wildcard_mask(addr);
          tbl_cmp[slot] = addr;
        end
      end
      REQ_REMOVE: begin
        m = wildcard_mask(addr);
        for (int i = 0; i < tbl_cnt && slot < 0; i++) begin
          if (tbl_msk[i] == m && tbl_cmp[i] == addr) slot = i;
        end
        if (slot < 0) begin
          v.status = STAT_NOT_FOUND;
          missed_removes++;
        end else begin
          for (int j = slot; j < tbl_cnt - 1; j++) begin
            tbl_msk[j] = tbl_msk[j+1];
            tbl_cmp[j] = tbl_cmp[j+1];
          end
          tbl_cnt--;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_pattern();
    logic [31:0] p;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: p[8*k +: 8] = 8'd0;
        3:       p[8*k +: 8] = 8'hFF;
        default: p[8*k +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    if ($urandom_range(0, 19) == 0) p = ALL_ONES;
    return p;
  endfunction

  function automatic logic [31:0] rand_match_addr();
    int idx;
    if (tbl_cnt > 0 && $urandom_range(0, 1) == 1) begin
      idx = $urandom_range(0, tbl_cnt - 1);
      return tbl_cmp[idx] | ($urandom & ~tbl_msk[idx]);
    end
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_remove_addr();
    if (tbl_cnt > 0 && $urandom_range(0, 99) < 65) begin
      return tbl_cmp[$urandom_range(0, tbl_cnt - 1)];
    end
    return rand_pattern();
  endfunction

  // Hold each transfer until taken; lower valid only when the burst ends.
  task automatic send_req(req_t req, logic [31:0] addr, bit typed, verdict_t typed_v);
    verdict_t v;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_ip_address <= addr;
    do @(posedge clk); while (in_stall);
    v = predict_verdict(req, addr);
    pending_verdicts.push_back(typed ? typed_v : v);
    items_sent++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic drain_queue();
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_ban(logic value);
    cfg_we <= 1'b1;
    cfg_ban_on_match <= value;
    ban_mode = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Phase mix: 0 fills the table, 1 mixes, 2 empties it out.
  task automatic send_random(int mix);
    int roll;
    int add_pct;
    int rem_pct;
    roll = $urandom_range(0, 99);
    add_pct = (mix == 0) ? 80 : (mix == 1) ? 35 : 15;
    rem_pct = (mix == 0) ? 5 : (mix == 1) ? 22 : 52;
    if (roll < 3) send_req(REQ_IGNORE, $urandom, 1'b0, '0);
    else if (roll < 3 + add_pct) send_req(REQ_ADD, rand_pattern(), 1'b0, '0);
    else if (roll < 3 + add_pct + rem_pct) send_req(REQ_REMOVE, rand_remove_addr(), 1'b0, '0);
    else send_req(REQ_MATCH, rand_match_addr(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, drop %0b status %0d", $time, out_drop, out_status);
      end else begin
        head_v = pending_verdicts.pop_front();
        results_seen++;
        if (head_v.drop !== out_drop) begin
          errors++;
          $display("%0t: drop expected %0b actual %0b", $time, head_v.drop, out_drop);
        end
        if (head_v.status !== out_status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, head_v.status, out_status);
        end
      end
    end
    if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_cnt % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    verdict_t typed_v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].cfg_row) begin
        drain_queue();
        write_ban(dir_table[r].ban);
      end else begin
        typed_v.drop = dir_table[r].drop;
        typed_v.status = dir_table[r].status;
        send_req(dir_table[r].req, dir_table[r].addr, dir_table[r].typed, typed_v);
      end
    end
    for (int p = 0; p < PHASES; p++) begin
      drain_queue();
      write_ban(p[0]);
      repeat (PHASE_ITEMS) send_random(p % 3);
    end
    drain_queue();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d requests, checked %0d results over %0d cycles",
             items_sent, results_seen, cycle_cnt);
    $display("table-full adds %0d, missed removes %0d, dropped matches %0d",
             full_adds, missed_removes, dropped_matches);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/maft_pkg.sv
src/maft_dp.sv
src/maft_ctrl.sv
src/masked_address_filter_table_core.sv
dv/tb_masked_address_filter_table_core.sv
